>>> rtl/core/fixed_point_alu_assert.svh
// Assertion macros for the fixed-point ALU
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Assert an implication at every clock edge outside reset
`define FPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication in the following cycle
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants
// Command codes, status codes and item structs of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam logic [3:0] CMD_ADD     = 4'd0;
    localparam logic [3:0] CMD_SUB     = 4'd1;
    localparam logic [3:0] CMD_MUL     = 4'd2;
    localparam logic [3:0] CMD_DIV     = 4'd3;
    localparam logic [3:0] CMD_CMP     = 4'd4;
    localparam logic [3:0] CMD_MIN     = 4'd5;
    localparam logic [3:0] CMD_MAX     = 4'd6;
    localparam logic [3:0] CMD_INC     = 4'd7;
    localparam logic [3:0] CMD_DEC     = 4'd8;
    localparam logic [3:0] CMD_FROMINT = 4'd9;
    localparam logic [3:0] CMD_TOINT   = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Divider quotient width: numerator below 2^49, plus one rounding bit
    localparam int QW = 50;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               is_greater;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
    } out_item_t;

    // Context carried alongside the divider chain
    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic signed [31:0] result_raw;
        logic               is_greater;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
        logic               neg;
    } ctx_t;

endpackage

>>> rtl/core/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max and conversions.
// ----------------------------------------------------------------------------
// Usage: raise start with an item (command and two raw operands); busy is
// never high, so one item is taken every cycle. Each item yields one result
// item on result, marked by done for exactly one cycle, in input order.
// Every item, whatever its command, passes through one front stage, a chain
// of QW restoring-divide cells, each producing one quotient bit a cycle and
// passing the item along, and one output stage. Throughput is one item per
// cycle, set by the divider cells all working in parallel.
// Multiply and divide round half away from zero; overflow saturates and
// reports status 2, divide by zero gives zero with status 1.
// Reset clears the valid bits of every stage; no item is in flight after.
// The receiver cannot stall: results are dropped if not taken in their cycle.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_assert.svh"

module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fpa_pkg::in_item_t   item,
    output logic                done,
    output fpa_pkg::out_item_t  result
);

    localparam int N = fpa_pkg::QW;

    fpa_pkg::ctx_t      ctx [N+1];
    logic [50:0]        rem [N+1];
    logic [N-1:0]       num [N+1];
    logic [32:0]        den [N+1];
    logic [N-1:0]       quo [N+1];
    logic signed [63:0] prod [N+1];

    assign busy = 1'b0;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .ctx   (ctx[0]),
        .num   (num[0]),
        .den   (den[0]),
        .prod  (prod[0])
    );

    assign rem[0] = '0;
    assign quo[0] = '0;

    // Chain of divide cells, most significant quotient bit first
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_div_cell #(.BIT(N - 1 - i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctx_in  (ctx[i]),
            .rem_in  (rem[i]),
            .num_in  (num[i]),
            .den_in  (den[i]),
            .quo_in  (quo[i]),
            .ctx_out (ctx[i+1]),
            .rem_out (rem[i+1]),
            .num_out (num[i+1]),
            .den_out (den[i+1]),
            .quo_out (quo[i+1])
        );

        // Carry the product along with the item
        always_ff @(posedge clk)
        begin
            prod[i+1] <= prod[i];
        end
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctx    (ctx[N]),
        .prod   (prod[N]),
        .quo    (quo[N]),
        .done   (done),
        .result (result)
    );

    `FPA_ASSERT_NEXT(a_strobe_follows, ctx[N].valid, done, "result strobe lost")
    `FPA_ASSERT_IMPL(a_flags_excl, done,
        $countones({result.is_greater, result.is_less, result.is_equal}) == 1,
        "compare flags not exclusive")
    `FPA_ASSERT_IMPL(a_div0_zero, done && result.status == fpa_pkg::ST_DIV0,
        result.result_raw == 32'sd0, "divide by zero gave non-zero result")

endmodule

>>> rtl/core/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-divide stage
// Produces one quotient bit and hands remainder and context to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpa_pkg::ctx_t        ctx_in,
    input  logic [50:0]          rem_in,
    input  logic [fpa_pkg::QW-1:0] num_in,
    input  logic [32:0]          den_in,
    input  logic [fpa_pkg::QW-1:0] quo_in,
    output fpa_pkg::ctx_t        ctx_out,
    output logic [50:0]          rem_out,
    output logic [fpa_pkg::QW-1:0] num_out,
    output logic [32:0]          den_out,
    output logic [fpa_pkg::QW-1:0] quo_out
);

    logic [50:0]             trial;
    logic [51:0]             diff;
    logic [fpa_pkg::QW-1:0]  quo_next;

    // Shift in the next numerator bit and try the subtract
    always_comb
    begin
        trial = {rem_in[49:0], num_in[BIT]};
        diff  = {1'b0, trial} - {19'd0, den_in};
        quo_next      = quo_in;
        quo_next[BIT] = !diff[51];
    end

    // Advance the context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_out <= '0;
        else
            ctx_out <= ctx_in;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        num_out <= num_in;
        den_out <= den_in;
        quo_out <= quo_next;
        if (!diff[51])
            rem_out <= diff[50:0];
        else
            rem_out <= trial;
    end

endmodule

>>> rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand decode and the short operations
// Registers everything except divide quotient; multiply uses one register.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fpa_pkg::in_item_t      item,
    output fpa_pkg::ctx_t          ctx,
    output logic [fpa_pkg::QW-1:0] num,
    output logic [32:0]            den,
    output logic signed [63:0]     prod
);

    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [33:0] sum;
    logic signed [33:0] dif;
    logic signed [33:0] inc;
    logic signed [33:0] dec;
    logic [32:0]        mag_a;
    logic [32:0]        mag_b;
    logic [63:0]        fi_mag;
    logic signed [31:0] toint;
    fpa_pkg::ctx_t      c;

    function automatic logic [33:0] sat34(input logic signed [33:0] v, output logic s);
        logic [33:0] r;
        begin
            s = 1'b0;
            r = v;
            if (v > 34'sd2147483647)
            begin
                s = 1'b1;
                r = 34'sd2147483647;
            end
            else if (v < -34'sd2147483648)
            begin
                s = 1'b1;
                r = -34'sd2147483648;
            end
            sat34 = r;
        end
    endfunction

    // Decode and compute the short operations
    always_comb
    begin
        logic s;
        logic [33:0] r;
        s     = 1'b0;
        r     = '0;
        a     = 33'(item.operand_a);
        b     = 33'(item.operand_b);
        sum   = 34'(a) + 34'(b);
        dif   = 34'(a) - 34'(b);
        inc   = 34'(a) + 34'sd1;
        dec   = 34'(a) - 34'sd1;
        mag_a = a[32] ? 33'(-a) : 33'(a);
        mag_b = b[32] ? 33'(-b) : 33'(b);
        fi_mag = 64'(mag_a) << FRAC_BITS;
        toint = item.operand_a >>> FRAC_BITS;
        c = '0;
        c.valid      = start;
        c.cmd        = item.cmd;
        c.is_greater = item.operand_a > item.operand_b;
        c.is_less    = item.operand_a < item.operand_b;
        c.is_equal   = item.operand_a == item.operand_b;
        c.neg        = a[32] ^ b[32];
        c.status     = fpa_pkg::ST_OK;
        unique case (item.cmd)
            fpa_pkg::CMD_ADD: r = sat34(sum, s);
            fpa_pkg::CMD_SUB: r = sat34(dif, s);
            fpa_pkg::CMD_INC: r = sat34(inc, s);
            fpa_pkg::CMD_DEC: r = sat34(dec, s);
            fpa_pkg::CMD_MIN: r = c.is_less ? 34'(a) : 34'(b);
            fpa_pkg::CMD_MAX: r = c.is_greater ? 34'(a) : 34'(b);
            fpa_pkg::CMD_TOINT: r = 34'(toint);
            fpa_pkg::CMD_FROMINT:
            begin
                if (a[32] && fi_mag > 64'd2147483648)
                begin
                    s = 1'b1;
                    r = -34'sd2147483648;
                end
                else if (!a[32] && fi_mag > 64'd2147483647)
                begin
                    s = 1'b1;
                    r = 34'sd2147483647;
                end
                else
                    r = a[32] ? -34'(fi_mag[33:0]) : 34'(fi_mag[33:0]);
            end
            fpa_pkg::CMD_DIV: if (item.operand_b == 32'sd0) c.status = fpa_pkg::ST_DIV0;
            default: r = '0;
        endcase
        c.result_raw = r[31:0];
        if (s)
            c.status = fpa_pkg::ST_SAT;
    end

    // Register the item's context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx <= '0;
        else
            ctx <= c;
    end

    // Register the divider operands and the product
    always_ff @(posedge clk)
    begin
        // Doubled numerator plus divisor, for rounding half away from zero
        num  <= fpa_pkg::QW'({fi_mag[48:0], 1'b0}) + fpa_pkg::QW'(mag_b);
        den  <= {mag_b[31:0], 1'b0};
        prod <= item.operand_a * item.operand_b;
    end

endmodule

>>> rtl/core/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result selection and saturation
// Rounds the product, clamps product and quotient and registers the item.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpa_pkg::ctx_t          ctx,
    input  logic signed [63:0]     prod,
    input  logic [fpa_pkg::QW-1:0] quo,
    output logic                   done,
    output fpa_pkg::out_item_t     result
);

    logic [63:0]        pmag;
    logic [63:0]        prnd;
    logic [63:0]        qmag;
    logic               neg;
    fpa_pkg::out_item_t r;

    // Pick the finished value for the item's command
    always_comb
    begin
        pmag = prod[63] ? 64'(-prod) : 64'(prod);
        prnd = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        qmag = 64'(quo);
        r.result_raw = ctx.result_raw;
        r.is_greater = ctx.is_greater;
        r.is_less    = ctx.is_less;
        r.is_equal   = ctx.is_equal;
        r.status     = ctx.status;
        neg = 1'b0;
        if (ctx.cmd == fpa_pkg::CMD_MUL || (ctx.cmd == fpa_pkg::CMD_DIV &&
            ctx.status != fpa_pkg::ST_DIV0))
        begin
            if (ctx.cmd == fpa_pkg::CMD_MUL)
            begin
                neg  = prod[63];
                qmag = prnd;
            end
            else
                neg = ctx.neg;
            if (neg && qmag > 64'd2147483648)
            begin
                r.result_raw = 32'h8000_0000;
                r.status     = fpa_pkg::ST_SAT;
            end
            else if (!neg && qmag > 64'd2147483647)
            begin
                r.result_raw = 32'h7fff_ffff;
                r.status     = fpa_pkg::ST_SAT;
            end
            else
                r.result_raw = neg ? -qmag[31:0] : qmag[31:0];
        end
    end

    // Register the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= ctx.valid;
    end

    // Register the item
    always_ff @(posedge clk)
    begin
        result <= r;
    end

endmodule
